// ===== sv/tmcw_pkg.sv =====
// Shared constants for the text-mode console writer.
// Used by the console core; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

  // Screen geometry
  localparam int COLUMNS     = 80;
  localparam int SCROLL_ROW  = 24;
  localparam int SCREEN_ROWS = 25;

  localparam int CELL_COUNT  = SCREEN_ROWS * COLUMNS;
  localparam int SCROLL_END  = SCROLL_ROW * COLUMNS;
  localparam int MOVED_CELLS = (SCROLL_ROW - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);

  // Field widths of the stream items
  localparam int CODE_W   = 9;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int BYTE_W   = 8;
  localparam int CELL_W   = 16;

  localparam int IN_TDATA_W  = 24;  // code + index = 20 bits, padded to bytes
  localparam int OUT_TDATA_W = 40;  // byte + cursor + cell = 35 bits, padded

  // Character codes
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00A;
  localparam logic [CODE_W-1:0] CODE_UP        = 9'h0E2;
  localparam logic [CODE_W-1:0] CODE_LEFT      = 9'h0E4;
  localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'h0E5;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;

  // Cell contents and echo bytes
  localparam logic [7:0]        ATTR_NORMAL = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0720;
  localparam logic [BYTE_W-1:0] ECHO_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] ECHO_SPACE  = 8'h20;

  // Request modes
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

endpackage : tmcw_pkg

`default_nettype wire

// ===== sv/text_mode_console_writer_core.sv =====
// Text-mode console core: screen store, cursor, scroll sequencer, serial echo.
// Depends on tmcw_pkg and tmcw_ram.
// A put request goes from ST_IDLE to ST_EMIT, a screen read through ST_READ to
// ST_EMIT, and a backspace gives three results from ST_EMIT; a new request is taken
// only once the last result is in the output register. A scroll adds ST_COPY, which
// moves the rows up, and ST_WIPE, which clears the last row from the cursor on.
// Reset: the cursor goes to 0 and a clearing pass zeroes all CELL_COUNT
// (2000) cells, one a cycle, before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_writer_core
  import tmcw_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [8:0] char_code, [19:9] cell_index
  input  wire logic                   s_axis_tuser,  // [0] mode
  // Result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [7:0] serial_byte,
                                                     // [18:8] cursor_position,
                                                     // [34:19] cell_value
  output logic                        m_axis_tuser,  // [0] serial_valid
  output logic                        m_axis_tlast   // last
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,  // clearing pass after reset
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,  // screen read data on its way out of the RAM
    ST_COPY   = 6'b001000,  // scroll: move rows up
    ST_WIPE   = 6'b010000,  // scroll: clear tail of the last row
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [ADDR_W-1:0]   idx_q, idx_d;       // sweep index for init, copy and wipe
  logic [CURSOR_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0]    col_q, col_d;       // column of the cursor, avoids a mod
  logic [1:0]          beat_q, beat_d;     // result number within a backspace
  logic                bs_q, bs_d;
  logic                rd_q, rd_d;         // request was a screen read
  logic                oor_q, oor_d;       // read index beyond the store

  // Payload registers
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic [CELL_W-1:0]   cell_q, cell_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   out_user_q, out_user_d;
  logic                   out_last_q, out_last_d;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Request fields
  logic                in_mode;
  logic [CODE_W-1:0]   in_code;
  logic [INDEX_W-1:0]  in_index;
  logic                in_accept;

  // Next-cursor arithmetic, one bit wider than the cursor
  logic [CURSOR_W:0]   cur_next;
  logic [COL_W-1:0]    col_next;
  logic                out_free;

  assign in_mode   = s_axis_tuser;
  assign in_code   = s_axis_tdata[CODE_W-1:0];
  assign in_index  = s_axis_tdata[CODE_W +: INDEX_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Cursor move for a put request
  always_comb begin
    cur_next = {1'b0, cursor_q};
    col_next = col_q;
    case (in_code)
      CODE_NEWLINE: begin
        cur_next = (CURSOR_W+1)'(cursor_q) + (CURSOR_W+1)'(COLUMNS)
                   - (CURSOR_W+1)'(col_q);
        col_next = '0;
      end
      CODE_BACKSPACE, CODE_LEFT: begin
        if (cursor_q != '0) begin
          cur_next = (CURSOR_W+1)'(cursor_q) - (CURSOR_W+1)'(1);
          col_next = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
        end
      end
      CODE_UP: begin
        // hold cursor
      end
      default: begin
        // right arrow and ordinary characters advance
        cur_next = (CURSOR_W+1)'(cursor_q) + (CURSOR_W+1)'(1);
        col_next = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    beat_d      = beat_q;
    bs_d        = bs_q;
    rd_d        = rd_q;
    oor_d       = oor_q;
    byte_d      = byte_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = ADDR_W'(in_index);

    case (state_q)
      ST_INIT: begin
        ram_we = 1'b1;
        idx_d  = idx_q + ADDR_W'(1);
        if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          beat_d = '0;
          byte_d = in_code[BYTE_W-1:0];
          bs_d   = (in_mode == MODE_PUT) && (in_code == CODE_BACKSPACE);
          rd_d   = (in_mode == MODE_READ);
          if (in_mode == MODE_READ) begin
            // issue the read now; data lands next cycle
            oor_d   = 32'(in_index) >= CELL_COUNT;
            state_d = ST_READ;
          end else begin
            cell_d   = '0;
            cursor_d = cur_next[CURSOR_W-1:0];
            col_d    = col_next;
            state_d  = ST_EMIT;
            if (in_code == CODE_BACKSPACE) begin
              // blank the cell under the moved-back cursor
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(cur_next);
              ram_wdata = BLANK_CELL;
            end else if (in_code != CODE_NEWLINE && in_code != CODE_LEFT &&
                         in_code != CODE_RIGHT && in_code != CODE_UP) begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(cursor_q);
              ram_wdata = {ATTR_NORMAL, in_code[7:0]};
            end
            if (32'(cur_next) >= SCROLL_END) begin
              // drop one row and start the scroll
              cursor_d = CURSOR_W'(cur_next - (CURSOR_W+1)'(COLUMNS));
              idx_d    = '0;
              state_d  = ST_COPY;
            end
          end
        end
      end

      ST_READ: begin
        cell_d  = oor_q ? '0 : ram_rdata;
        state_d = ST_EMIT;
      end

      ST_COPY: begin
        // read cell idx+COLUMNS, write the cell read last cycle to idx-1
        ram_raddr = idx_q + ADDR_W'(COLUMNS);
        if (idx_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        idx_d = idx_q + ADDR_W'(1);
        if (idx_q == ADDR_W'(MOVED_CELLS)) begin
          idx_d   = ADDR_W'(cursor_q);
          state_d = ST_WIPE;
        end
      end

      ST_WIPE: begin
        if (32'(idx_q) < SCROLL_END) begin
          ram_we = 1'b1;
          idx_d  = idx_q + ADDR_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (rd_q) begin
            out_data_d = OUT_TDATA_W'({cell_q, cursor_q, BYTE_W'(0)});
            out_user_d = 1'b0;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else if (bs_q) begin
            // echo 08 20 08
            out_data_d = OUT_TDATA_W'({CELL_W'(0), cursor_q,
                                       (beat_q == 2'd1) ? ECHO_SPACE : ECHO_BS});
            out_user_d = 1'b1;
            out_last_d = (beat_q == 2'd2);
            beat_d     = beat_q + 2'd1;
            if (beat_q == 2'd2) begin
              state_d = ST_IDLE;
            end
          end else begin
            out_data_d = OUT_TDATA_W'({CELL_W'(0), cursor_q, byte_q});
            out_user_d = 1'b1;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idx_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      beat_q      <= '0;
      bs_q        <= 1'b0;
      rd_q        <= 1'b0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      beat_q      <= beat_d;
      bs_q        <= bs_d;
      rd_q        <= rd_d;
      oor_q       <= oor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    cell_q     <= cell_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The cursor never rests on or past the scroll row.
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) < SCROLL_END)
    else $error("cursor beyond scroll row");

  // The column register tracks a valid column.
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS)
    else $error("column out of range");

  // The wipe sweep never starts below the cursor.
  a_wipe_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WIPE) |-> (32'(idx_q) >= 32'(cursor_q)))
    else $error("wipe index below cursor");

  // A new scroll copy starts at cell zero right after a request.
  a_copy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && $past(state_q) == ST_IDLE) |-> (idx_q == '0))
    else $error("scroll copy started mid-screen");

endmodule : text_mode_console_writer_core

`default_nettype wire

// ===== sv/tmcw_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule : tmcw_ram

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the text-mode console core: drives put and read requests,
// predicts echo bytes, cursor and screen cells, and checks every result in order.
// Depends on tmcw_pkg and text_mode_console_writer_core.
`timescale 1ns / 1ps

module testbench;
  import tmcw_pkg::*;

  localparam int STALL_LIMIT  = 20000;  // cycles with no transfer before giving up
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 64;     // quiet time after the last result
  localparam int PHASE_ITEMS  = 41;     // random requests per idling phase
  localparam int PHASES       = 5;
  localparam int DIRECTED_N   = 24;

  // One result as seen on the output stream
  typedef struct packed {
    logic [BYTE_W-1:0]   echo_byte;
    logic                echo_valid;
    logic                is_last;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_val;
  } console_result_t;

  // One directed request; typed rows carry the single result they must give
  typedef struct packed {
    logic                mode;
    logic [CODE_W-1:0]   code;
    logic [INDEX_W-1:0]  index;
    logic                typed;
    logic [BYTE_W-1:0]   echo;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_val;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = MODE_PUT;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  // Console state as the predictor sees it
  logic [CELL_W-1:0] screen_model [CELL_COUNT] = '{default: '0};
  int                cursor_model = 0;
  console_result_t   pending_results [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic hold_request = 1'b0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  int  errors = 0;
  int  requests_sent = 0;
  int  results_checked = 0;
  int  scroll_count = 0;
  int  reads_sent = 0;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{MODE_READ, 9'h000,         11'd0,    1'b1, 8'h00, 11'd0,  16'h0000}, // cleared store
    '{MODE_READ, 9'h000,         11'd1999, 1'b1, 8'h00, 11'd0,  16'h0000}, // last cell
    '{MODE_READ, 9'h0FF,         11'd2000, 1'b1, 8'h00, 11'd0,  16'h0000}, // just past end
    '{MODE_READ, 9'h000,         11'd2047, 1'b1, 8'h00, 11'd0,  16'h0000}, // top index
    '{MODE_PUT,  CODE_LEFT,      11'd0,    1'b1, 8'hE4, 11'd0,  16'h0000}, // no step below 0
    '{MODE_PUT,  CODE_UP,        11'd0,    1'b1, 8'hE2, 11'd0,  16'h0000}, // no effect
    '{MODE_PUT,  CODE_BACKSPACE, 11'd0,    1'b0, 8'h00, 11'd0,  16'h0000}, // backspace at 0
    '{MODE_READ, 9'h000,         11'd0,    1'b1, 8'h00, 11'd0,  16'h0720}, // blanked cell
    '{MODE_PUT,  9'h041,         11'd0,    1'b1, 8'h41, 11'd1,  16'h0000},
    '{MODE_READ, 9'h000,         11'd0,    1'b1, 8'h00, 11'd1,  16'h0741},
    '{MODE_PUT,  9'h0FF,         11'h7FF,  1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_PUT,  9'h000,         11'd0,    1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_PUT,  CODE_RIGHT,     11'd0,    1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_PUT,  CODE_NEWLINE,   11'd0,    1'b1, 8'h0A, 11'd80, 16'h0000},
    '{MODE_PUT,  CODE_BACKSPACE, 11'd0,    1'b0, 8'h00, 11'd0,  16'h0000}, // back over a row
    '{MODE_READ, 9'h000,         11'd79,   1'b1, 8'h00, 11'd79, 16'h0720},
    '{MODE_READ, 9'h000,         11'd1,    1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_READ, 9'h000,         11'd2,    1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_READ, 9'h000,         11'd3,    1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_READ, 9'h000,         11'h555,  1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_READ, 9'h000,         11'h2AA,  1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_PUT,  9'h0AA,         11'h555,  1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_PUT,  9'h055,         11'h2AA,  1'b0, 8'h00, 11'd0,  16'h0000},
    '{MODE_PUT,  CODE_LEFT,      11'd0,    1'b0, 8'h00, 11'd0,  16'h0000}
  };

  text_mode_console_writer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [8:0] char_code, [19:9] cell_index
    .s_axis_tuser  (s_axis_tuser),   // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] serial_byte, [18:8] cursor_position,
                                     // [34:19] cell_value
    .m_axis_tuser  (m_axis_tuser),   // [0] serial_valid
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Work out the results of one accepted request and advance the console state.
  task automatic predict_console(input logic mode, input logic [CODE_W-1:0] code,
                                 input logic [INDEX_W-1:0] index);
    console_result_t r;
    int pos;
    r = '0;
    if (mode == MODE_READ) begin
      // Reads leave the state alone; cells past the store read as zero
      r.is_last    = 1'b1;
      r.cursor_pos = CURSOR_W'(cursor_model);
      r.cell_val   = (int'(index) < CELL_COUNT) ? screen_model[index] : '0;
      pending_results.push_back(r);
      return;
    end
    if (code == CODE_NEWLINE) begin
      cursor_model += COLUMNS - cursor_model % COLUMNS;
    end else if (code == CODE_BACKSPACE || code == CODE_LEFT) begin
      if (cursor_model > 0) cursor_model--;
    end else if (code == CODE_RIGHT) begin
      cursor_model++;
    end else if (code != CODE_UP) begin
      if (cursor_model < CELL_COUNT) screen_model[cursor_model] = {ATTR_NORMAL, code[7:0]};
      cursor_model++;
    end
    // Cursor hit the scroll row: shift rows up, pull the cursor back, clear the tail
    if (cursor_model / COLUMNS >= SCROLL_ROW) begin
      for (pos = 0; pos < MOVED_CELLS; pos++) screen_model[pos] = screen_model[pos + COLUMNS];
      cursor_model -= COLUMNS;
      for (pos = cursor_model; pos < SCROLL_END; pos++) screen_model[pos] = '0;
      scroll_count++;
    end
    r.echo_valid = 1'b1;
    r.cursor_pos = CURSOR_W'(cursor_model);
    if (code == CODE_BACKSPACE) begin
      // Erase under the cursor and echo back-space, space, back-space
      screen_model[cursor_model] = BLANK_CELL;
      r.echo_byte = ECHO_BS;
      pending_results.push_back(r);
      r.echo_byte = ECHO_SPACE;
      pending_results.push_back(r);
      r.echo_byte = ECHO_BS;
      r.is_last   = 1'b1;
      pending_results.push_back(r);
    end else begin
      r.echo_byte = code[7:0];
      r.is_last   = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // Offer one request after a random idle gap; return at the edge that takes it.
  task automatic send_request(input logic mode, input logic [CODE_W-1:0] code,
                              input logic [INDEX_W-1:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({index, code});
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_console(mode, code, index);
    requests_sent++;
    if (mode == MODE_READ) reads_sent++;
  endtask

  // Drop the request valid and hold until every expected result has come back.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request from the stimulus.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    console_result_t want;
    console_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{echo_byte: m_axis_tdata[7:0], echo_valid: m_axis_tuser,
              is_last: m_axis_tlast, cursor_pos: m_axis_tdata[18:8],
              cell_val: m_axis_tdata[34:19]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte %h valid %b last %b cursor %0d cell %h",
                 $time, got.echo_byte, got.echo_valid, got.is_last, got.cursor_pos,
                 got.cell_val);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected byte %h valid %b last %b cursor %0d cell %h",
                   $time, want.echo_byte, want.echo_valid, want.is_last, want.cursor_pos,
                   want.cell_val);
          $display("%0t:           actual   byte %h valid %b last %b cursor %0d cell %h",
                   $time, got.echo_byte, got.echo_valid, got.is_last, got.cursor_pos,
                   got.cell_val);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic                mode;
    logic [CODE_W-1:0]   code;
    logic [INDEX_W-1:0]  index;
    int                  sel;
    int                  line_left;
    int                  phase;
    int                  k;
    console_result_t     typed_result;

    line_left = 2;
    // Hold reset, then release; the core clears its store before taking requests
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: typed rows replace the predicted entry with the literal one
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].mode, directed_rows[i].code, directed_rows[i].index);
      if (directed_rows[i].typed) begin
        typed_result = '{echo_byte: directed_rows[i].echo,
                         echo_valid: (directed_rows[i].mode == MODE_PUT), is_last: 1'b1,
                         cursor_pos: directed_rows[i].cursor_pos,
                         cell_val: directed_rows[i].cell_val};
        pending_results[pending_results.size() - 1] = typed_result;
      end
    end
    pause_until_drained();

    // Random text in phases of idling; each phase ends with a full drain
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Stall the output for a long stretch while requests keep coming
        if ((phase == 0 || phase == PHASES - 1) && k == 8) hold_request <= 1'b1;
        sel   = $urandom_range(99);
        mode  = MODE_PUT;
        code  = CODE_W'($urandom_range(256));
        index = INDEX_W'($urandom_range(2047));
        if (sel < 20) begin
          // Reads: mostly near the cursor, some anywhere, a few past the store
          mode = MODE_READ;
          case ($urandom_range(9))
            0, 1, 2, 3, 4:
              index = (cursor_model > 160) ? INDEX_W'(cursor_model - $urandom_range(160))
                                           : INDEX_W'($urandom_range(cursor_model));
            9:       index = INDEX_W'($urandom_range(2047, CELL_COUNT));
            default: index = INDEX_W'($urandom_range(CELL_COUNT - 1));
          endcase
        end else if (sel < 26) begin
          code = CODE_BACKSPACE;
        end else if (sel < 29) begin
          code = CODE_LEFT;
        end else if (sel < 32) begin
          code = CODE_RIGHT;
        end else if (sel < 34) begin
          code = CODE_UP;
        end else if (line_left > 0) begin
          code = CODE_W'($urandom_range(255));
          line_left--;
        end else begin
          // End the line; near the bottom, sometimes start one that runs off the row
          code = CODE_NEWLINE;
          if (cursor_model / COLUMNS >= SCROLL_ROW - 2 && $urandom_range(3) == 0)
            line_left = $urandom_range(85, 70);
          else
            line_left = $urandom_range(4);
        end
        send_request(mode, code, index);
      end
      pause_until_drained();
    end

    // Let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests (%0d cell reads), %0d results checked, %0d scrolls.",
             requests_sent, reads_sent, results_checked, scroll_count);
    $display("Phases: free-running, sender idle, receiver stall, both; %0d mismatches.",
             errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
